FILE: rtl/core/u8ld_pkg.sv
package u8ld_pkg;

  // code point width and the replacement character
  localparam int unsigned CP_W = 21;
  typedef logic [CP_W-1:0] cp_t;

  localparam cp_t REPLACEMENT_CP = 21'h00FFFD;

  // lengths of an open sequence
  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  // range limits used by the completion check
  localparam cp_t MIN_TWO      = 21'h000080;
  localparam cp_t MIN_THREE    = 21'h000800;
  localparam cp_t MIN_FOUR     = 21'h010000;
  localparam cp_t SURR_LO      = 21'h00D800;
  localparam cp_t SURR_HI      = 21'h00DFFF;
  localparam cp_t MAX_SCALAR   = 21'h10FFFF;

  // byte classes
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_CODE = 8'h80;

endpackage

FILE: rtl/core/utf8_lossy_decoder.sv
// channel | ports                                          | direction
// --------+------------------------------------------------+----------
// in      | in_valid, in_ready, in_data_byte, in_end_of_text | into block
// out     | out_valid, out_ready, out_code_point,            | out of block
//         | out_run_last, out_text_done                     |
//
// A word is decoded in one pass from the input register into the result
// register; its group of results (zero to four) leaves one per cycle while
// out_ready is high, a word with more results holds the input register until
// its last is taken, and words with at most one result keep one word per cycle.
// Reset (rst_n low at a clock edge) clears the open sequence and both stages.
// When out_ready is low the group holds and in_ready falls once the input
// register is full, whatever the waiting word would yield.
module utf8_lossy_decoder
  import u8ld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic        out_run_last,
  output logic        out_text_done
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eot_r;

  // decoder state
  logic [2:0] seq_len_r, seq_len_nxt;
  logic [1:0] seen_r, seen_nxt;
  cp_t        part_r, part_nxt;

  // result group register: remaining count, final code point, end flag
  logic [2:0] out_cnt_r, out_cnt_nxt;
  cp_t        out_last_r;
  logic       out_eot_r;

  logic       out_free;
  logic       s1_adv;

  // decode signals
  logic       consumed;
  logic       is_cont;
  logic       have_x;
  cp_t        x_cp;
  cp_t        acc;
  logic [1:0] seen_inc;
  logic [1:0] nflush;
  logic [1:0] eflush;
  logic       eflush_en;
  logic [2:0] k_total;
  cp_t        last_cp;

  // completion check of a full sequence
  function automatic cp_t check_value(input logic [2:0] len, input cp_t cp);
    logic bad;
    begin
      if (len == LEN_TWO) begin
        bad = (cp < MIN_TWO);
      end else if (len == LEN_THREE) begin
        bad = (cp < MIN_THREE) || ((cp >= SURR_LO) && (cp <= SURR_HI));
      end else begin
        bad = (cp < MIN_FOUR) || (cp > MAX_SCALAR);
      end
      check_value = bad ? REPLACEMENT_CP : cp;
    end
  endfunction

  // handshake
  assign out_free = (out_cnt_r == 3'd0) || ((out_cnt_r == 3'd1) && out_ready);
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || s1_adv;

  // one pass over the held word
  always_comb begin
    seq_len_nxt = seq_len_r;
    seen_nxt    = seen_r;
    part_nxt    = part_r;
    consumed    = 1'b0;
    have_x      = 1'b0;
    x_cp        = REPLACEMENT_CP;
    nflush      = 2'd0;
    is_cont     = ((s1_byte_r & CONT_MASK) == CONT_CODE);
    acc         = {part_r[CP_W-7:0], s1_byte_r[5:0]};
    seen_inc    = seen_r + 2'd1;

    // continue or interrupt an open sequence
    if (seq_len_r != LEN_NONE) begin
      if (is_cont) begin
        consumed = 1'b1;
        if (({1'b0, seen_inc} + 3'd1) >= seq_len_r) begin
          have_x      = 1'b1;
          x_cp        = check_value(seq_len_r, acc);
          seq_len_nxt = LEN_NONE;
          seen_nxt    = 2'd0;
          part_nxt    = '0;
        end else begin
          seen_nxt = seen_inc;
          part_nxt = acc;
        end
      end else begin
        nflush      = seen_inc;
        seq_len_nxt = LEN_NONE;
        seen_nxt    = 2'd0;
        part_nxt    = '0;
      end
    end

    // fresh byte
    if (!consumed) begin
      if (!s1_byte_r[7]) begin
        have_x = 1'b1;
        x_cp   = {13'd0, s1_byte_r};
      end else if (s1_byte_r[7:5] == 3'b110) begin
        seq_len_nxt = LEN_TWO;
        seen_nxt    = 2'd0;
        part_nxt    = {16'd0, s1_byte_r[4:0]};
      end else if (s1_byte_r[7:4] == 4'b1110) begin
        seq_len_nxt = LEN_THREE;
        seen_nxt    = 2'd0;
        part_nxt    = {17'd0, s1_byte_r[3:0]};
      end else if (s1_byte_r[7:3] == 5'b11110) begin
        seq_len_nxt = LEN_FOUR;
        seen_nxt    = 2'd0;
        part_nxt    = {18'd0, s1_byte_r[2:0]};
      end else begin
        have_x = 1'b1;
        x_cp   = REPLACEMENT_CP;
      end
    end

    // end of text flushes what is still open
    eflush_en = s1_eot_r && (seq_len_nxt != LEN_NONE);
    eflush    = eflush_en ? (seen_nxt + 2'd1) : 2'd0;
    if (eflush_en) begin
      seq_len_nxt = LEN_NONE;
      seen_nxt    = 2'd0;
      part_nxt    = '0;
    end

    k_total = {1'b0, nflush} + {2'b00, have_x} + {1'b0, eflush};
    last_cp = have_x ? x_cp : REPLACEMENT_CP;
  end

  // result count
  always_comb begin
    out_cnt_nxt = out_cnt_r;
    if (s1_adv) begin
      out_cnt_nxt = k_total;
    end else if (out_valid && out_ready) begin
      out_cnt_nxt = out_cnt_r - 3'd1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      seq_len_r  <= LEN_NONE;
      seen_r     <= 2'd0;
      part_r     <= '0;
      out_cnt_r  <= 3'd0;
    end else begin
      out_cnt_r <= out_cnt_nxt;
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        seq_len_r <= seq_len_nxt;
        seen_r    <= seen_nxt;
        part_r    <= part_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_eot_r  <= in_end_of_text;
    end
    if (s1_adv) begin
      out_last_r <= last_cp;
      out_eot_r  <= s1_eot_r;
    end
  end

  // result outputs: replacements first, the final code point last
  assign out_valid      = (out_cnt_r != 3'd0);
  assign out_run_last   = (out_cnt_r == 3'd1);
  assign out_text_done  = (out_cnt_r == 3'd1) && out_eot_r;
  assign out_code_point = (out_cnt_r == 3'd1) ? out_last_r : REPLACEMENT_CP;

  // checks
  a_eot_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_eot_r) |=> (seq_len_r == LEN_NONE))
    else $error("sequence left open after end of text");

  a_eot_yields: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_eot_r) |=> (out_cnt_r != 3'd0))
    else $error("end of text word gave no result");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_len_r != LEN_NONE) |-> (({1'b0, seen_r} + 3'd1) < seq_len_r))
    else $error("buffered continuations exceed sequence length");

  a_len_code: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_len_r == LEN_NONE) || (seq_len_r == LEN_TWO) ||
    (seq_len_r == LEN_THREE) || (seq_len_r == LEN_FOUR))
    else $error("bad sequence length");

  a_group_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_cnt_r == $past(out_cnt_r)))
    else $error("result group moved while stalled");

endmodule
